>>> src/cpr_pkg.sv
// Shared types and constants for the clock page replacement unit.
// No dependencies; imported by every module of the block.
package cpr_pkg;

  localparam int unsigned PAGE_W  = 16;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CFG_W   = 5;

  localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic              end_of_run;
  } cpr_in_t;

  typedef struct packed {
    logic               hit;
    logic               fault;
    logic [INDEX_W-1:0] frame_index;
    logic [COUNT_W-1:0] fault_count;
  } cpr_out_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic lookup;
    logic sweep;
    logic emit;
  } cpr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_sweep;
    logic victim_found;
    logic out_free;
  } cpr_sts_t;

endpackage

>>> src/cpr_ctrl.sv
// Sequencer of the clock page replacement unit: accept, lookup, hand sweep, emit.
// Depends on cpr_pkg for the command and status structs.
module cpr_ctrl import cpr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  cpr_sts_t sts_i,
  output cpr_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        if (sts_i.need_sweep) begin
          state_d = ST_SWEEP;
        end else if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.victim_found) begin
          state_d = sts_i.out_free ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/cpr_datapath.sv
// Frame store, use bits, hand, counters and output register of the clock unit.
// Depends on cpr_pkg; driven by cpr_ctrl through cpr_cmd_t.
module cpr_datapath import cpr_pkg::*; #(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  cpr_in_t          in_data_i,
  input  cpr_cmd_t         cmd_i,
  output cpr_sts_t         sts_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cpr_out_t         out_data_o
);

  localparam int unsigned PW   = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int unsigned FIDX = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW   = $clog2(FRAMES + 1);
  localparam int unsigned NW   = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0]   cfg_q;
  logic [PW-1:0]      page_q;
  logic               eor_q;
  logic [PW-1:0]      frame_q [FRAMES];
  logic [FRAMES-1:0]  use_q, use_d;
  logic [NW-1:0]      filled_q, filled_d;
  logic [FIDX-1:0]    hand_q, hand_d;
  logic [COUNT_W-1:0] faults_q, faults_d, faults_inc;
  cpr_out_t           hold_q, res;
  cpr_out_t           out_q;
  logic               out_valid_q;

  logic [NW-1:0]      n_act, cfg_ext, hand_inc;
  logic [FIDX-1:0]    hand_nxt, hit_idx, where;
  logic [FRAMES-1:0]  match;
  logic               found, full, hand_use, commit, out_free, load_out;
  logic               frame_we;

  // active frame count, clamped to 1..FRAMES
  always_comb begin
    cfg_ext = NW'(cfg_q);
    if (cfg_q == '0) begin
      n_act = NW'(1);
    end else if (cfg_ext > NW'(FRAMES)) begin
      n_act = NW'(FRAMES);
    end else begin
      n_act = cfg_ext;
    end
  end

  assign hand_inc = NW'(hand_q) + NW'(1);
  assign hand_nxt = (hand_inc >= n_act) ? '0 : hand_inc[FIDX-1:0];

  // parallel compare against filled frames, lowest match wins
  always_comb begin
    hit_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      match[i] = (frame_q[i] == page_q) && (NW'(i) < filled_q) && (NW'(i) < n_act);
      if (match[i]) begin
        hit_idx = FIDX'(i);
      end
    end
  end

  assign found      = |match;
  assign full       = !(filled_q < n_act);
  assign hand_use   = use_q[hand_q];
  assign faults_inc = (faults_q == COUNT_MAX) ? faults_q : faults_q + 1'b1;

  assign out_free = !out_valid_q || !out_stall_i;
  assign commit   = (cmd_i.lookup && !(!found && full)) || (cmd_i.sweep && !hand_use);
  assign load_out = out_free && (commit || cmd_i.emit);

  assign sts_o.need_sweep   = cmd_i.lookup && !found && full;
  assign sts_o.victim_found = !hand_use;
  assign sts_o.out_free     = out_free;

  always_comb begin
    use_d    = use_q;
    filled_d = filled_q;
    hand_d   = hand_q;
    faults_d = faults_q;
    where    = '0;
    frame_we = 1'b0;
    res      = '0;
    res.fault_count = faults_q;

    if (cmd_i.accept) begin
      // hand beyond a lowered count wraps before use
      if (NW'(hand_q) >= n_act) begin
        hand_d = '0;
      end
    end else if (cmd_i.lookup) begin
      if (found) begin
        where        = hit_idx;
        use_d[where] = 1'b1;
        res.hit      = 1'b1;
      end else if (!full) begin
        where        = filled_q[FIDX-1:0];
        frame_we     = 1'b1;
        use_d[where] = 1'b1;
        filled_d     = filled_q + NW'(1);
        hand_d       = hand_nxt;
      end
    end else if (cmd_i.sweep) begin
      if (hand_use) begin
        use_d[hand_q] = 1'b0;
        hand_d        = hand_nxt;
      end else begin
        where           = hand_q;
        frame_we        = 1'b1;
        use_d[where]    = 1'b1;
        hand_d          = hand_nxt;
        faults_d        = faults_inc;
        res.fault       = 1'b1;
        res.fault_count = faults_inc;
      end
    end
    res.frame_index = INDEX_W'(where);

    if (commit && eor_q) begin
      use_d    = '0;
      filled_d = '0;
      hand_d   = '0;
      faults_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      use_q       <= '0;
      filled_q    <= '0;
      hand_q      <= '0;
      faults_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      use_q    <= use_d;
      filled_q <= filled_d;
      hand_q   <= hand_d;
      faults_q <= faults_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      page_q <= in_data_i.page_number[PW-1:0];
      eor_q  <= in_data_i.end_of_run;
    end
    if (frame_we) begin
      frame_q[where] <= page_q;
    end
    if (commit) begin
      hold_q <= res;
    end
    if (load_out) begin
      out_q <= commit ? res : hold_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> src/clock_page_replacement_unit.sv
// Clock (second-chance) page replacement unit. Each transfer on the input is one
// page reference; each produces exactly one result transfer with hit, fault, the
// frame holding the page and the running fault count. A hit or a fill of an empty
// frame goes through accept, then a parallel compare over the filled frames. A miss
// with all frames full goes on into a sweep in which the hand passes and clears set
// use bits (at most the active frame count) until it finds a clear one to replace;
// the hand steps one frame per cycle. References are processed one at a time; a finished result
// goes to the output register. If that register still holds a stalled result, the
// new one waits in a holding register and the unit stays busy, in its emit state,
// for as long as the output stays stalled.
// Depends on cpr_pkg, cpr_ctrl and cpr_datapath.
module clock_page_replacement_unit import cpr_pkg::*; #(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cpr_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cpr_out_t         out_data_o
);

  cpr_cmd_t cmd;
  cpr_sts_t sts;

  cpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cpr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> src/cpr_checker.sv
// Port-level checks for clock_page_replacement_unit, attached by bind.
// Depends on cpr_pkg for the result struct.
module cpr_checker import cpr_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_i,
  input logic     out_valid_i,
  input logic     out_stall_i,
  input cpr_out_t out_data_i
);

  // one reference in flight: the transfer after an accept is stalled
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("input accepted in the cycle after an accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or dropped");

  a_hit_xor_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_data_i.hit && out_data_i.fault))
    else $error("result flags both hit and fault");

  a_fault_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.fault |-> out_data_i.fault_count != '0)
    else $error("fault reported with zero fault count");

endmodule

bind clock_page_replacement_unit cpr_checker u_cpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

>>> sim/clock_page_replacement_unit_tb.sv
// Self-checking testbench for clock_page_replacement_unit: a queue-fed driver and a
// result monitor against a second-chance predictor kept alongside the block.
// Depends on cpr_pkg and the RTL under src.
module clock_page_replacement_unit_tb;
  import cpr_pkg::*;

  localparam int unsigned FRAMES    = 16;
  localparam int unsigned PAGE_BITS = 16;
  localparam int unsigned ONE_FRAME_REFS = 20;

  typedef enum logic [1:0] {
    STEP_REFERENCE,
    STEP_CONFIG,
    STEP_DRAIN,
    STEP_PACE
  } step_kind_e;

  typedef struct packed {
    step_kind_e       kind;
    cpr_in_t          item;
    logic [CFG_W-1:0] setting;
    logic [6:0]       idle_pct;
    logic [6:0]       stall_pct;
  } step_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = CFG_RESET;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  cpr_in_t          in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  cpr_out_t         out_data_o;

  step_t    reference_q[$];
  cpr_out_t outcome_q[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int failures         = 0;
  int references_sent  = 0;
  int settings_written = 0;
  int hits_seen        = 0;
  int faults_seen      = 0;

  // Tracked copy of the replacement state
  logic [CFG_W-1:0]   frame_count_q = CFG_RESET;
  logic [PAGE_W-1:0]  resident_page [FRAMES];
  bit                 use_flag      [FRAMES];
  logic [CFG_W-1:0]   filled_q      = '0;
  logic [INDEX_W-1:0] hand_q        = '0;
  logic [COUNT_W-1:0] faults_q      = '0;

  clock_page_replacement_unit #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic cpr_out_t clock_resolve(input cpr_in_t item);
    cpr_out_t           res;
    int                 n;
    int                 searched;
    int                 i;
    bit                 found;
    logic [INDEX_W-1:0] slot;
    n = (frame_count_q == 0) ? 1 : ((frame_count_q > FRAMES) ? FRAMES : int'(frame_count_q));
    searched = (int'(filled_q) < n) ? int'(filled_q) : n;
    found = 1'b0;
    slot = '0;
    res = '0;
    if (int'(hand_q) >= n) hand_q = '0;
    for (i = 0; i < searched; i++) begin
      if (!found && resident_page[i] == item.page_number) begin
        found = 1'b1;
        slot = INDEX_W'(i);
      end
    end
    if (found) begin
      res.hit = 1'b1;
      use_flag[slot] = 1'b1;
    end else if (int'(filled_q) < n) begin
      slot = INDEX_W'(filled_q);
      resident_page[slot] = item.page_number;
      use_flag[slot] = 1'b1;
      filled_q = filled_q + 1'b1;
      hand_q = (int'(hand_q) + 1 >= n) ? '0 : hand_q + 1'b1;
    end else begin
      // second chance: clear set bits until a clear one turns up
      for (i = 0; i <= n && use_flag[hand_q]; i++) begin
        use_flag[hand_q] = 1'b0;
        hand_q = (int'(hand_q) + 1 >= n) ? '0 : hand_q + 1'b1;
      end
      slot = hand_q;
      resident_page[slot] = item.page_number;
      use_flag[slot] = 1'b1;
      hand_q = (int'(hand_q) + 1 >= n) ? '0 : hand_q + 1'b1;
      res.fault = 1'b1;
      if (faults_q != COUNT_MAX) faults_q = faults_q + 1'b1;
    end
    res.frame_index = slot;
    res.fault_count = faults_q;
    if (item.end_of_run) begin
      foreach (use_flag[k]) use_flag[k] = 1'b0;
      filled_q = '0;
      hand_q   = '0;
      faults_q = '0;
    end
    return res;
  endfunction

  task automatic add_reference(input logic [PAGE_W-1:0] page, input logic last);
    step_t s;
    s = '0;
    s.kind = STEP_REFERENCE;
    s.item.page_number = page;
    s.item.end_of_run = last;
    reference_q.push_back(s);
  endtask

  task automatic add_config(input logic [CFG_W-1:0] setting);
    step_t s;
    s = '0;
    s.kind = STEP_CONFIG;
    s.setting = setting;
    reference_q.push_back(s);
  endtask

  task automatic add_drain();
    step_t s;
    s = '0;
    s.kind = STEP_DRAIN;
    reference_q.push_back(s);
  endtask

  task automatic add_pace(input int unsigned idle, input int unsigned stall);
    step_t s;
    s = '0;
    s.kind = STEP_PACE;
    s.idle_pct = 7'(idle);
    s.stall_pct = 7'(stall);
    reference_q.push_back(s);
  endtask

  // Working set a little larger than the active frames, so the hand keeps turning
  task automatic random_phase(input int count);
    logic [PAGE_W-1:0] pool[$];
    logic [PAGE_W-1:0] page;
    logic [CFG_W-1:0]  setting;
    int                active;
    int                until_cfg;
    until_cfg = 0;
    for (int k = 0; k < count; k++) begin
      if (until_cfg == 0) begin
        case ($urandom_range(5))
          0:       setting = 5'd1;
          1:       setting = 5'd16;
          2:       setting = 5'd0;
          3:       setting = 5'($urandom_range(31, 17));
          default: setting = 5'($urandom_range(16, 2));
        endcase
        add_config(setting);
        active = (setting == 0) ? 1 : ((setting > FRAMES) ? FRAMES : int'(setting));
        pool.delete();
        repeat (active + $urandom_range(4)) pool.push_back(PAGE_W'($urandom()));
        until_cfg = $urandom_range(70, 30);
      end
      until_cfg--;
      if ($urandom_range(99) < 2) add_drain();
      if ($urandom_range(99) < 12) page = PAGE_W'($urandom());
      else page = pool[$urandom_range(pool.size() - 1)];
      add_reference(page, $urandom_range(99) < 3);
    end
  endtask

  // Driver: one control step per cycle while the input channel is free
  always @(posedge clk_i) begin
    step_t            head;
    logic             next_valid;
    cpr_in_t          next_data;
    logic             next_we;
    logic [CFG_W-1:0] next_wdata;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_we_i   <= 1'b0;
    end else begin
      next_valid = in_valid_i;
      next_data  = in_data_i;
      next_we    = 1'b0;
      next_wdata = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        outcome_q.push_back(clock_resolve(in_data_i));
        references_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid && reference_q.size() != 0) begin
        head = reference_q[0];
        case (head.kind)
          STEP_PACE: begin
            send_idle_pct  = 32'(head.idle_pct);
            recv_stall_pct = 32'(head.stall_pct);
            void'(reference_q.pop_front());
          end
          STEP_DRAIN: begin
            if (outcome_q.size() == 0) void'(reference_q.pop_front());
          end
          STEP_CONFIG: begin
            // register changes only with nothing in flight
            if (outcome_q.size() == 0) begin
              next_we       = 1'b1;
              next_wdata    = head.setting;
              frame_count_q = head.setting;
              settings_written++;
              void'(reference_q.pop_front());
            end
          end
          default: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              next_valid = 1'b1;
              next_data  = head.item;
              void'(reference_q.pop_front());
            end
          end
        endcase
      end
      in_valid_i  <= next_valid;
      in_data_i   <= next_data;
      cfg_we_i    <= next_we;
      cfg_wdata_i <= next_wdata;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      failures++;
      // cap the log on a badly broken block
      if (failures <= 200) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Monitor: compares each result transfer with the oldest outstanding outcome
  always @(posedge clk_i) begin
    cpr_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          failures++;
          $error("result transfer with no reference outstanding: %p", out_data_o);
        end else begin
          want = outcome_q.pop_front();
          check_field("hit", 32'(want.hit), 32'(out_data_o.hit));
          check_field("fault", 32'(want.fault), 32'(out_data_o.fault));
          check_field("frame_index", 32'(want.frame_index), 32'(out_data_o.frame_index));
          check_field("fault_count", 32'(want.fault_count), 32'(out_data_o.fault_count));
        end
        if (out_data_o.hit) hits_seen++;
        if (out_data_o.fault) faults_seen++;
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    logic [PAGE_W-1:0] page_a;
    logic [PAGE_W-1:0] page_b;

    // Directed: field extremes, fill, full sweep, lowered count, duplicate pages
    add_pace(7, 87);
    add_config(5'd16);
    add_reference(16'h0000, 1'b0);
    add_reference(16'hFFFF, 1'b0);
    add_reference(16'hAAAA, 1'b0);
    add_reference(16'h5555, 1'b0);
    for (int i = 4; i < FRAMES; i++) add_reference(PAGE_W'((i << 12) | i), 1'b0);
    add_reference(16'hFFFF, 1'b0);
    add_reference(16'h8001, 1'b0);
    // shrink the count: the page in frame 9 is out of reach and gets a second copy
    add_config(5'd4);
    add_reference(16'h9009, 1'b0);
    add_config(5'd16);
    add_reference(16'h9009, 1'b0);
    add_reference(16'h7FFE, 1'b1);
    add_config(5'd0);
    add_reference(16'h0001, 1'b0);
    add_reference(16'h0002, 1'b0);
    add_reference(16'h0001, 1'b0);
    add_config(5'd31);
    add_reference(16'h0003, 1'b0);
    add_reference(16'h0003, 1'b1);

    add_pace(7, 87);
    add_drain();
    random_phase(200);
    add_pace(87, 7);
    add_drain();
    random_phase(200);
    add_pace(0, 0);
    add_drain();
    random_phase(200);

    // One frame, two pages in turn: every reference after the first faults, up to the end of the run
    page_a = PAGE_W'($urandom());
    page_b = ~page_a;
    add_config(5'd1);
    for (int i = 0; i < ONE_FRAME_REFS; i++)
      add_reference((i % 2) ? page_b : page_a, i == ONE_FRAME_REFS - 1);
    add_reference(page_a, 1'b0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (reference_q.size() != 0 || in_valid_i || outcome_q.size() != 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("%0d page references checked (%0d hits, %0d faults),",
             references_sent, hits_seen, faults_seen);
    $display("%0d frame count writes, idling 7/87, 87/7 and none, one-frame fault run.",
             settings_written);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> clock_page_replacement_unit.f
src/cpr_pkg.sv
src/cpr_ctrl.sv
src/cpr_datapath.sv
src/clock_page_replacement_unit.sv
src/cpr_checker.sv
sim/clock_page_replacement_unit_tb.sv
